FILE: src/mbs_pkg.sv
// Shared constants and operation codes for the multiword scaler.
`default_nettype none
package mbs_pkg;
    localparam int WORDS = 8;
    localparam int WORD_W = 32;
    localparam int IDX_W = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int CNT_W = $clog2(WORDS + 1);
    localparam int SH_W = $clog2((WORDS + 1) * 32 + 512) + 1;
    localparam int DIVC_W = $clog2(WORD_W + 1);

    localparam logic [2:0] MODE_CLEAR = 3'd0;
    localparam logic [2:0] MODE_INS_LOW = 3'd1;
    localparam logic [2:0] MODE_INS_TOP = 3'd2;
    localparam logic [2:0] MODE_DIVIDE = 3'd3;
    localparam logic [2:0] MODE_MULTIPLY = 3'd4;
    localparam logic [2:0] MODE_TEST = 3'd5;

    typedef struct packed {
        logic start;
        logic [WORD_W-1:0] rem_in;
        logic [WORD_W-1:0] num_in;
        logic [WORD_W-1:0] divisor;
    } mbs_div_req_t;

    typedef struct packed {
        logic done;
        logic [WORD_W-1:0] quot;
        logic [WORD_W-1:0] rem;
    } mbs_div_rsp_t;
endpackage
`default_nettype wire

FILE: src/multiword_bignum_scaler_top.sv
// Top level of the multiword scaler: word memory, sequencer and output register.
// Usage:
//   s_tdata carries one command per transfer: mode, operand word and shift.
//   m_tdata returns one result per command: result word, all-zero and error flags.
//   The number lives in a WORDS-entry word memory with a registered read,
//   walked one word at a time by a read, modify, write sequence.
//   Work per command:
//     clear, test zero, zero divisor, empty insert: straight to the output register
//     insert: read, OR in and write each touched word (at most two words)
//     multiply: per word a 32x32 product register, then a carry add and write
//     divide: per word a 32-step radix-2 divider, then a write of the quotient
//   One command is in work at a time; s_tready is high only when idle.
//   A finished result waits in the output register; the next command is taken
//   meanwhile, and its result waits until the previous one is transferred.
//   Reset empties the output register and makes the number read as zero.
`default_nettype none
module multiword_bignum_scaler_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,  // mode[2:0], word_in[34:3], bit_shift[43:35], zero pad
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata   // result_word[31:0], all_zero[32], divide_error[33], pad
);
    import mbs_pkg::*;

    typedef enum logic [2:0] {IDLE, RD, EX, DIV, MUL, WR, FIN} state_t;

    state_t              state_reg;
    logic [2:0]          mode_reg;
    logic [WORD_W-1:0]   word_reg;
    logic [IDX_W-1:0]    idx_reg;
    logic [CNT_W-1:0]    left_reg;
    logic                sel_hi_reg;
    logic                err_reg;
    logic [WORD_W-1:0]   ins_hi_reg, ins_lo_reg;
    logic [WORD_W-1:0]   acc_reg;
    logic [WORD_W-1:0]   wdata_reg;
    logic [2*WORD_W-1:0] prod_reg;
    logic [WORDS-1:0]    vld_reg;
    logic [WORDS-1:0]    nz_reg;
    logic                out_valid_reg;
    logic [WORD_W-1:0]   out_res_reg;
    logic                out_zero_reg;
    logic                out_err_reg;

    logic [WORD_W-1:0]   mem [WORDS];
    logic [WORD_W-1:0]   rdata_reg;
    logic                rvld_reg;

    logic [2:0]          in_mode;
    logic [WORD_W-1:0]   in_word;
    logic [8:0]          in_shift;
    logic signed [SH_W-1:0] shv, tix;
    logic [2*WORD_W-1:0] wide;
    logic [WORD_W-1:0]   operand;
    logic [2*WORD_W-1:0] psum;
    logic                accept;
    logic                mem_we;
    mbs_div_req_t        dreq;
    mbs_div_rsp_t        drsp;

    assign in_mode = s_tdata[2:0];
    assign in_word = s_tdata[34:3];
    assign in_shift = s_tdata[43:35];
    assign s_tready = (state_reg == IDLE);
    assign accept = s_tvalid && s_tready;
    assign mem_we = (state_reg == WR);

    always_comb
    begin
        if (in_mode == MODE_INS_TOP)
            shv = SH_W'((WORDS + 1) * 32) - SH_W'(in_shift);
        else
            shv = SH_W'(in_shift);
        tix = SH_W'(WORDS - 1) - (shv >>> 5);
        wide = {{WORD_W{1'b0}}, in_word} << shv[4:0];
        operand = rvld_reg ? rdata_reg : '0;
        psum = prod_reg + {{WORD_W{1'b0}}, acc_reg};
        dreq.start = (state_reg == EX) && (mode_reg == MODE_DIVIDE);
        dreq.rem_in = acc_reg;
        dreq.num_in = operand;
        dreq.divisor = word_reg;
    end

    mbs_div u_div (
        .clk(clk),
        .rst_n(rst_n),
        .req(dreq),
        .rsp(drsp)
    );

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[idx_reg] <= wdata_reg;
        if (state_reg == RD)
            rdata_reg <= mem[idx_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IDLE;
            vld_reg <= '0;
            nz_reg <= '0;
            rvld_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            idx_reg <= '0;
            left_reg <= '0;
            sel_hi_reg <= 1'b0;
            err_reg <= 1'b0;
            mode_reg <= MODE_TEST;
        end
        else
        begin
            if (out_valid_reg && m_tready && state_reg != FIN)
                out_valid_reg <= 1'b0;
            case (state_reg)
                IDLE:
                begin
                    if (accept)
                    begin
                        mode_reg <= in_mode;
                        word_reg <= in_word;
                        err_reg <= (in_mode == MODE_DIVIDE) && (in_word == '0);
                        acc_reg <= '0;
                        ins_hi_reg <= wide[2*WORD_W-1:WORD_W];
                        ins_lo_reg <= wide[WORD_W-1:0];
                        case (in_mode)
                            MODE_CLEAR:
                            begin
                                vld_reg <= '0;
                                nz_reg <= '0;
                                state_reg <= FIN;
                            end
                            MODE_INS_LOW, MODE_INS_TOP:
                            begin
                                if (shv > 0 && tix >= -1)
                                begin
                                    state_reg <= RD;
                                    sel_hi_reg <= (tix >= 0);
                                    idx_reg <= (tix < 0) ? '0 : IDX_W'(tix);
                                    left_reg <= (tix == -1 || tix == SH_W'(WORDS - 1))
                                        ? CNT_W'(1) : CNT_W'(2);
                                end
                                else
                                    state_reg <= FIN;
                            end
                            MODE_DIVIDE:
                            begin
                                if (in_word == '0)
                                    state_reg <= FIN;
                                else
                                begin
                                    state_reg <= RD;
                                    idx_reg <= '0;
                                    left_reg <= CNT_W'(WORDS);
                                end
                            end
                            MODE_MULTIPLY:
                            begin
                                state_reg <= RD;
                                idx_reg <= IDX_W'(WORDS - 1);
                                left_reg <= CNT_W'(WORDS);
                            end
                            default:
                                state_reg <= FIN;
                        endcase
                    end
                end
                RD:
                begin
                    rvld_reg <= vld_reg[idx_reg];
                    state_reg <= EX;
                end
                EX:
                begin
                    case (mode_reg)
                        MODE_DIVIDE:
                            state_reg <= DIV;
                        MODE_MULTIPLY:
                        begin
                            prod_reg <= word_reg * operand;
                            state_reg <= MUL;
                        end
                        default:
                        begin
                            wdata_reg <= operand | (sel_hi_reg ? ins_hi_reg : ins_lo_reg);
                            state_reg <= WR;
                        end
                    endcase
                end
                DIV:
                begin
                    if (drsp.done)
                    begin
                        wdata_reg <= drsp.quot;
                        acc_reg <= drsp.rem;
                        state_reg <= WR;
                    end
                end
                MUL:
                begin
                    wdata_reg <= psum[WORD_W-1:0];
                    acc_reg <= psum[2*WORD_W-1:WORD_W];
                    state_reg <= WR;
                end
                WR:
                begin
                    vld_reg[idx_reg] <= 1'b1;
                    nz_reg[idx_reg] <= |wdata_reg;
                    sel_hi_reg <= 1'b0;
                    left_reg <= left_reg - 1'b1;
                    if (left_reg == CNT_W'(1))
                        state_reg <= FIN;
                    else
                    begin
                        state_reg <= RD;
                        if (mode_reg == MODE_MULTIPLY)
                            idx_reg <= idx_reg - 1'b1;
                        else
                            idx_reg <= idx_reg + 1'b1;
                    end
                end
                FIN:
                begin
                    if (!out_valid_reg || m_tready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_res_reg <= (mode_reg == MODE_DIVIDE || mode_reg == MODE_MULTIPLY)
                            ? acc_reg : '0;
                        out_zero_reg <= ~|nz_reg;
                        out_err_reg <= err_reg;
                        state_reg <= IDLE;
                    end
                end
                default:
                    state_reg <= IDLE;
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata = {6'b0, out_err_reg, out_zero_reg, out_res_reg};

    a_err_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[33] |-> m_tdata[31:0] == '0)
        else $error("error result carries data");
    a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        drsp.done |-> state_reg == DIV) else $error("divider done outside divide");
    a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg == FIN)) else $error("result loaded outside finish");
    a_write_counts: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == WR |-> left_reg != '0) else $error("write with no words left");
endmodule
`default_nettype wire

FILE: src/mbs_div.sv
// Radix-2 restoring divider: {rem_in, num_in} / divisor, rem_in below divisor.
`default_nettype none
module mbs_div (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire mbs_pkg::mbs_div_req_t req,
    output mbs_pkg::mbs_div_rsp_t      rsp
);
    import mbs_pkg::*;

    logic [WORD_W-1:0] rem_reg, rem_next;
    logic [WORD_W-1:0] q_reg, q_next;
    logic [WORD_W-1:0] d_reg;
    logic [DIVC_W-1:0] cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [WORD_W:0]   trial;
    logic              ge;

    always_comb
    begin
        trial = {rem_reg, q_reg[WORD_W-1]};
        ge = (trial >= {1'b0, d_reg});
        rem_next = ge ? WORD_W'(trial - {1'b0, d_reg}) : trial[WORD_W-1:0];
        q_next = {q_reg[WORD_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg <= DIVC_W'(WORD_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIVC_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= req.rem_in;
            q_reg <= req.num_in;
            d_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            q_reg <= q_next;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = q_reg;
    assign rsp.rem = rem_reg;

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg)) else $error("done without busy");
    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && cnt_reg != DIVC_W'(1) |=> busy_reg || done_reg)
        else $error("divider dropped busy");
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> rem_reg < d_reg) else $error("remainder not below divisor");
endmodule
`default_nettype wire

FILE: test/tb_top.sv
// Testbench for the multiword scaler: random and directed commands checked against a predictor.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
    import mbs_pkg::*;

    typedef struct packed {
        logic [31:0] result_word;
        logic        all_zero;
        logic        divide_error;
    } scaler_result_t;

    class scaler_scoreboard;
        logic [31:0] num_words [WORDS];
        scaler_result_t pending [$];
        int errors;
        int checked;

        function new();
            errors = 0;
            checked = 0;
            foreach (num_words[i]) num_words[i] = '0;
        endfunction

        function void or_shifted(logic [31:0] value, int shift);
            logic [63:0] wide;
            int top_idx;
            if (shift <= 0) return;
            wide = {32'd0, value} << (shift % 32);
            top_idx = WORDS - 1 - shift / 32;
            if (top_idx >= 0 && top_idx < WORDS) num_words[top_idx] |= wide[63:32];
            if (top_idx + 1 >= 0 && top_idx + 1 < WORDS) num_words[top_idx + 1] |= wide[31:0];
        endfunction

        function void note_command(logic [2:0] mode, logic [31:0] word_in, logic [8:0] shamt);
            scaler_result_t r;
            logic [63:0] acc;
            logic [31:0] carry;
            r = '0;
            case (mode)
                MODE_CLEAR: foreach (num_words[i]) num_words[i] = '0;
                MODE_INS_LOW: or_shifted(word_in, int'(shamt));
                MODE_INS_TOP: or_shifted(word_in, (WORDS + 1) * 32 - int'(shamt));
                MODE_DIVIDE:
                begin
                    if (word_in == 0)
                        r.divide_error = 1'b1;
                    else
                    begin
                        acc = '0;
                        for (int i = 0; i < WORDS; i++)
                        begin
                            acc = {acc[31:0], num_words[i]};
                            num_words[i] = 32'(acc / word_in);
                            acc = acc % word_in;
                        end
                        r.result_word = acc[31:0];
                    end
                end
                MODE_MULTIPLY:
                begin
                    carry = '0;
                    for (int i = WORDS - 1; i >= 0; i--)
                    begin
                        acc = 64'(word_in) * 64'(num_words[i]) + 64'(carry);
                        num_words[i] = acc[31:0];
                        carry = acc[63:32];
                    end
                    r.result_word = carry;
                end
                default: ;
            endcase
            r.all_zero = 1'b1;
            foreach (num_words[i]) if (num_words[i] != 0) r.all_zero = 1'b0;
            pending.push_back(r);
        endfunction

        function void check_result(logic [39:0] data);
            scaler_result_t exp_r;
            if (pending.size() == 0)
            begin
                $error("unexpected result %h", data);
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            checked++;
            if (data[31:0] !== exp_r.result_word)
            begin
                $error("result_word expected %h actual %h", exp_r.result_word, data[31:0]);
                errors++;
            end
            if (data[32] !== exp_r.all_zero)
            begin
                $error("all_zero expected %b actual %b", exp_r.all_zero, data[32]);
                errors++;
            end
            if (data[33] !== exp_r.divide_error)
            begin
                $error("divide_error expected %b actual %b", exp_r.divide_error, data[33]);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic s_tvalid;
    logic s_tready;
    logic [47:0] s_tdata;  // mode, word_in, bit_shift, pad
    logic m_tvalid;
    logic m_tready;
    logic [39:0] m_tdata;  // result_word, all_zero, divide_error, pad

    scaler_scoreboard sb;
    bit idle_on;
    int sent;
    int mode_hits [8];

    multiword_bignum_scaler_top dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    task automatic send_command(logic [2:0] mode, logic [31:0] word_in, logic [8:0] shamt);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {4'd0, shamt, word_in, mode};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sb.note_command(mode, word_in, shamt);
        mode_hits[mode]++;
        sent++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return 32'(1) << $urandom_range(0, 31);
            3: return $urandom_range(1, 16);
            default: return $urandom;
        endcase
    endfunction

    task automatic fill_number();
        for (int i = 1; i <= WORDS; i++)
            send_command(MODE_INS_LOW, $urandom, 9'(i * 32));
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata);
        if (idle_on && $urandom_range(0, 5) == 0)
            m_tready <= 1'b0;
        else if (!idle_on || !m_tready || $urandom_range(0, 1) == 0)
            m_tready <= 1'b1;
    end

    initial
    begin
        #20000000;
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        sb = new();
        idle_on = 1'b0;
        sent = 0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed
        send_command(MODE_TEST, 32'd0, 9'd0);
        send_command(MODE_INS_LOW, 32'hFFFF_FFFF, 9'd0);
        send_command(MODE_INS_LOW, 32'h8000_0001, 9'd1);
        send_command(MODE_INS_LOW, 32'hDEAD_BEEF, 9'd32);
        send_command(MODE_INS_TOP, 32'h0000_0001, 9'd1);
        send_command(MODE_INS_TOP, 32'h1234_5678, 9'd32);
        send_command(MODE_INS_TOP, 32'hFFFF_FFFF, 9'd0);
        send_command(MODE_INS_TOP, 32'hFFFF_FFFF, 9'd511);
        send_command(MODE_INS_LOW, 32'hFFFF_FFFF, 9'd511);
        send_command(MODE_INS_LOW, 32'hA5A5_A5A5, 9'd256);
        send_command(MODE_INS_TOP, 32'h5A5A_5A5A, 9'd288);
        send_command(MODE_DIVIDE, 32'd0, 9'd0);
        send_command(MODE_DIVIDE, 32'hFFFF_FFFF, 9'd0);
        send_command(MODE_DIVIDE, 32'd1, 9'd0);
        send_command(MODE_MULTIPLY, 32'hFFFF_FFFF, 9'd0);
        send_command(MODE_MULTIPLY, 32'd0, 9'd0);
        send_command(MODE_INS_LOW, 32'd7, 9'd32);
        send_command(MODE_DIVIDE, 32'd8, 9'd0);
        send_command(MODE_CLEAR, 32'hFFFF_FFFF, 9'h1FF);
        send_command(3'd6, 32'hFFFF_FFFF, 9'h1FF);
        send_command(3'd7, 32'd0, 9'd0);
        wait_drained();

        idle_on = 1'b1;
        for (int n = 0; n < 760; n++)
        begin
            if (n == 600) idle_on = 1'b0;
            if (n == 300) wait_drained();
            case ($urandom_range(0, 19))
                0: send_command(MODE_CLEAR, $urandom, 9'($urandom));
                1, 2: fill_number();
                3, 4, 5: send_command(MODE_INS_LOW, rand_word(), 9'($urandom));
                6, 7: send_command(MODE_INS_TOP, rand_word(), 9'($urandom));
                8, 9, 10, 11: send_command(MODE_DIVIDE, rand_word(), 9'($urandom));
                12, 13, 14, 15: send_command(MODE_MULTIPLY, rand_word(), 9'($urandom));
                16: send_command(MODE_TEST, $urandom, 9'($urandom));
                17: send_command(3'($urandom_range(6, 7)), $urandom, 9'($urandom));
                default: send_command(MODE_INS_LOW, $urandom, 9'($urandom_range(1, 288)));
            endcase
        end
        wait_drained();
        repeat (400) @(posedge clk);

        $display("Covered %0d commands: %0d divides, %0d multiplies, %0d inserts,",
                 sent, mode_hits[MODE_DIVIDE], mode_hits[MODE_MULTIPLY],
                 mode_hits[MODE_INS_LOW] + mode_hits[MODE_INS_TOP]);
        $display("with output stalls and idle gaps; %0d results checked.", sb.checked);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
`default_nettype wire
